// ----- design/l2x_pkg.sv -----
// ----------------------------------------------------------------------------
// l2x_pkg: shared constants for the L*a*b* to XYZ converter
// Fixed-point formats, division reciprocals, pipeline depth and register
// indexes used by the top level and the channel datapath.
// ----------------------------------------------------------------------------
package l2x_pkg;

    // Input and output values carry FRAC_BITS fraction bits; f and the channel
    // ratio carry GUARD_FRAC fraction bits.
    localparam int FRAC_BITS  = 8;
    localparam int GUARD_FRAC = FRAC_BITS + 16;

    // Register stages from the input transfer to the output register.
    localparam int NSTAGE = 10;

    // Field widths.
    localparam int L_W       = 15;
    localparam int AB_W      = 16;
    localparam int WHITE_W   = 16;
    localparam int OUT_W     = 18;
    localparam int S_DATA_W  = ((L_W + 2 * AB_W + 7) / 8) * 8;
    localparam int M_DATA_W  = ((3 * OUT_W + 7) / 8) * 8;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHITE_Z = 2'd2;

    // D65 reference white, units of 1/256.
    localparam logic [WHITE_W-1:0] WHITE_X_RST = 16'd24332;
    localparam logic [WHITE_W-1:0] WHITE_Y_RST = 16'd25600;
    localparam logic [WHITE_W-1:0] WHITE_Z_RST = 16'd27874;

    // L* plus 16, in input units.
    localparam int              LS_W     = L_W + 1;
    localparam logic [LS_W-1:0] L_OFFSET = 16'(16 << FRAC_BITS);

    // The three front divisions round half away from zero on a magnitude
    // scaled by 2^16. The scale and the rounding bias are first divided by
    // the power of two shared with the divisor, which leaves an odd divisor.
    // Each quotient is then an exact multiply by ceil(2^K/D) and a shift,
    // with K = numerator width + ceil(log2(D)).
    localparam int FY_SHIFT = 14;   // 2^16 / 4, divisor 116 = 4 * 29
    localparam int FY_BIAS  = 14;   // floor(58 / 4)
    localparam int FY_DIV   = 29;
    localparam int FY_K     = 35;
    localparam int FX_SHIFT = 14;   // 2^16 / 4, divisor 500 = 4 * 125
    localparam int FX_BIAS  = 62;   // floor(250 / 4)
    localparam int FX_DIV   = 125;
    localparam int FX_K     = 37;
    localparam int FZ_SHIFT = 13;   // 2^16 / 8, divisor 200 = 8 * 25
    localparam int FZ_BIAS  = 12;   // floor(100 / 8)
    localparam int FZ_DIV   = 25;
    localparam int FZ_K     = 34;

    localparam int NUMY_W  = LS_W + FY_SHIFT;
    localparam int NUMX_W  = AB_W + FX_SHIFT;
    localparam int NUMZ_W  = AB_W + FZ_SHIFT;
    localparam int RECIP_W = 31;
    localparam int PRODY_W = NUMY_W + RECIP_W;
    localparam int PRODX_W = NUMX_W + RECIP_W;
    localparam int PRODZ_W = NUMZ_W + RECIP_W;

    localparam logic [RECIP_W-1:0] RECIP_Y =
        31'(((64'd1 << FY_K) + FY_DIV - 1) / FY_DIV);
    localparam logic [RECIP_W-1:0] RECIP_X =
        31'(((64'd1 << FX_K) + FX_DIV - 1) / FX_DIV);
    localparam logic [RECIP_W-1:0] RECIP_Z =
        31'(((64'd1 << FZ_K) + FZ_DIV - 1) / FZ_DIV);

    // Quotient widths: fy, |a|/500 and |b|/200 in guard format.
    localparam int QY_W = 25;
    localparam int QX_W = 23;
    localparam int QZ_W = 24;

    // f is signed; its range stays inside 26 bits for every input pattern.
    localparam int F_W = 26;
    localparam int M_W = F_W - 1;

    // Cube branch.
    localparam int SQP_W   = 2 * M_W;
    localparam int SQ_W    = SQP_W - GUARD_FRAC + 1;
    localparam int CUP_W   = SQ_W + M_W;
    localparam int CU_W    = 28;
    localparam int RATIO_W = CU_W + 1;
    localparam int RMAG_W  = CU_W;
    localparam logic signed [RATIO_W-1:0] CUBE_EPS =
        29'((64'd8856 * (64'd1 << GUARD_FRAC) + 64'd500000) / 64'd1000000);

    // Linear branch: round((116*f - 16*2^G) * 10 / 9033). Above LIN_CAP the
    // cube branch always wins, so f is clamped there to bound the numerator.
    localparam logic signed [F_W-1:0] LIN_CAP = 26'sd4194304;
    localparam int LIN_N_W    = 36;
    localparam int LIN_V_W    = 34;
    localparam int LIN_LO_W   = 17;
    localparam int LIN_HI_W   = LIN_V_W - LIN_LO_W;
    localparam int LIN_DIV    = 9033;
    localparam int LIN_K      = 48;
    localparam int LIN_R_W    = 35;
    localparam int LIN_PP_W   = LIN_HI_W + LIN_R_W;
    localparam int LIN_SUM_W  = LIN_PP_W + LIN_LO_W;
    localparam int LIN_Q_W    = 21;
    localparam logic signed [LIN_N_W-1:0] LIN_MULT   = 36'sd1160;
    localparam logic signed [LIN_N_W-1:0] LIN_OFFSET =
        36'(64'd10 * (64'd16 << GUARD_FRAC));
    localparam logic [LIN_V_W-1:0] LIN_ROUND = 34'(LIN_DIV / 2);
    localparam logic [LIN_R_W-1:0] RECIP_LIN =
        35'(((64'd1 << LIN_K) + LIN_DIV - 1) / LIN_DIV);

    // White scaling: ratio (G fraction bits) times white (8 fraction bits)
    // divided by 2^24 gives FRAC_BITS fraction bits.
    localparam int WPROD_W   = RMAG_W + WHITE_W;
    localparam int OSHIFT    = 24;
    localparam int ORND_W    = WPROD_W - OSHIFT + 1;
    localparam int OUT_HIGH  = 131071;
    localparam int OUT_LOW_M = 4096;
    localparam logic signed [OUT_W-1:0] OUT_LOW = -18'sd4096;

endpackage

// ----- design/l2x_channel.sv -----
// ----------------------------------------------------------------------------
// l2x_channel: one tristimulus channel of the L*a*b* to XYZ converter
// Takes f in guard format, picks the cube or the linear segment, scales by
// the reference white and saturates. Stages 2 to 9 of the shared pipeline.
// ----------------------------------------------------------------------------
module l2x_channel (
    input  logic                                   clk,
    input  logic [l2x_pkg::NSTAGE-1:0]             ld,
    input  logic signed [l2x_pkg::F_W-1:0]         f,
    input  logic [l2x_pkg::WHITE_W-1:0]            white,
    output logic [l2x_pkg::OUT_W-1:0]              tristim
);

    // Stage 2: magnitude of f and the linear numerator.
    logic signed [l2x_pkg::F_W-1:0]     f_abs;
    logic signed [l2x_pkg::F_W-1:0]     f_lin;
    logic [l2x_pkg::M_W-1:0]            m2_reg, m2_next;
    logic                               neg2_reg, neg2_next;
    logic signed [l2x_pkg::LIN_N_W-1:0] n2_reg, n2_next;

    // Stage 3: square and the linear magnitude with rounding bias.
    logic signed [l2x_pkg::LIN_N_W-1:0] n_abs;
    logic [l2x_pkg::SQP_W-1:0]          sqp3_reg, sqp3_next;
    logic [l2x_pkg::M_W-1:0]            m3_reg;
    logic                               neg3_reg;
    logic [l2x_pkg::LIN_V_W-1:0]        v3_reg, v3_next;
    logic                               lneg3_reg, lneg3_next;

    // Stage 4: rounded square and the reciprocal partial products.
    logic [l2x_pkg::SQP_W:0]            sq_sum;
    logic [l2x_pkg::SQ_W-1:0]           sq4_reg, sq4_next;
    logic [l2x_pkg::M_W-1:0]            m4_reg;
    logic                               neg4_reg;
    logic [l2x_pkg::LIN_PP_W-1:0]       lph4_reg, lph4_next;
    logic [l2x_pkg::LIN_PP_W-1:0]       lpl4_reg, lpl4_next;
    logic                               lneg4_reg;

    // Stage 5: cube product and the linear quotient.
    logic [l2x_pkg::CUP_W-1:0]          cup5_reg, cup5_next;
    logic                               neg5_reg;
    logic [l2x_pkg::LIN_SUM_W-1:0]      lin_sum;
    logic [l2x_pkg::LIN_Q_W-1:0]        lq5_reg, lq5_next;
    logic                               lneg5_reg;

    // Stage 6: signed cube and signed linear value.
    logic [l2x_pkg::CUP_W:0]            cu_sum;
    logic [l2x_pkg::CU_W-1:0]           cu_mag;
    logic signed [l2x_pkg::RATIO_W-1:0] cube6_reg, cube6_next;
    logic signed [l2x_pkg::RATIO_W-1:0] lin6_reg, lin6_next;

    // Stage 7: segment choice, kept as sign and magnitude.
    logic signed [l2x_pkg::RATIO_W-1:0] ratio;
    logic signed [l2x_pkg::RATIO_W-1:0] ratio_abs;
    logic [l2x_pkg::RMAG_W-1:0]         rmag7_reg, rmag7_next;
    logic                               neg7_reg, neg7_next;

    // Stage 8: white scaling.
    logic [l2x_pkg::WPROD_W-1:0]        wp8_reg, wp8_next;
    logic                               neg8_reg;

    // Stage 9: rounding and saturation.
    logic [l2x_pkg::WPROD_W:0]          o_sum;
    logic [l2x_pkg::ORND_W-1:0]         o_mag;
    logic [l2x_pkg::OUT_W-1:0]          tristim_reg, tristim_next;

    always_comb
    begin
        f_abs     = f[l2x_pkg::F_W-1] ? -f : f;
        m2_next   = f_abs[l2x_pkg::M_W-1:0];
        neg2_next = f[l2x_pkg::F_W-1];
        f_lin     = (f > l2x_pkg::LIN_CAP) ? l2x_pkg::LIN_CAP : f;
        n2_next   = l2x_pkg::LIN_N_W'(f_lin) * l2x_pkg::LIN_MULT - l2x_pkg::LIN_OFFSET;
    end

    always_comb
    begin
        sqp3_next  = l2x_pkg::SQP_W'(m2_reg) * l2x_pkg::SQP_W'(m2_reg);
        n_abs      = n2_reg[l2x_pkg::LIN_N_W-1] ? -n2_reg : n2_reg;
        v3_next    = n_abs[l2x_pkg::LIN_V_W-1:0] + l2x_pkg::LIN_ROUND;
        lneg3_next = n2_reg[l2x_pkg::LIN_N_W-1];
    end

    always_comb
    begin
        sq_sum    = (l2x_pkg::SQP_W+1)'(sqp3_reg)
                  + ((l2x_pkg::SQP_W+1)'(1) << (l2x_pkg::GUARD_FRAC - 1));
        sq4_next  = sq_sum[l2x_pkg::GUARD_FRAC +: l2x_pkg::SQ_W];
        lph4_next = l2x_pkg::LIN_PP_W'(v3_reg[l2x_pkg::LIN_V_W-1:l2x_pkg::LIN_LO_W])
                  * l2x_pkg::LIN_PP_W'(l2x_pkg::RECIP_LIN);
        lpl4_next = l2x_pkg::LIN_PP_W'(v3_reg[l2x_pkg::LIN_LO_W-1:0])
                  * l2x_pkg::LIN_PP_W'(l2x_pkg::RECIP_LIN);
    end

    always_comb
    begin
        cup5_next = l2x_pkg::CUP_W'(sq4_reg) * l2x_pkg::CUP_W'(m4_reg);
        lin_sum   = {lph4_reg, {l2x_pkg::LIN_LO_W{1'b0}}}
                  + l2x_pkg::LIN_SUM_W'(lpl4_reg);
        lq5_next  = lin_sum[l2x_pkg::LIN_K +: l2x_pkg::LIN_Q_W];
    end

    always_comb
    begin
        cu_sum     = (l2x_pkg::CUP_W+1)'(cup5_reg)
                   + ((l2x_pkg::CUP_W+1)'(1) << (l2x_pkg::GUARD_FRAC - 1));
        // The true cube stays below 2^27, so the upper bits are zero.
        cu_mag     = cu_sum[l2x_pkg::GUARD_FRAC +: l2x_pkg::CU_W];
        cube6_next = neg5_reg ? -$signed({1'b0, cu_mag}) : $signed({1'b0, cu_mag});
        lin6_next  = lneg5_reg ? -$signed(l2x_pkg::RATIO_W'(lq5_reg))
                               : $signed(l2x_pkg::RATIO_W'(lq5_reg));
    end

    always_comb
    begin
        ratio      = (cube6_reg > l2x_pkg::CUBE_EPS) ? cube6_reg : lin6_reg;
        ratio_abs  = ratio[l2x_pkg::RATIO_W-1] ? -ratio : ratio;
        rmag7_next = ratio_abs[l2x_pkg::RMAG_W-1:0];
        neg7_next  = ratio[l2x_pkg::RATIO_W-1];
    end

    always_comb
    begin
        wp8_next = l2x_pkg::WPROD_W'(rmag7_reg) * l2x_pkg::WPROD_W'(white);
    end

    always_comb
    begin
        o_sum = (l2x_pkg::WPROD_W+1)'(wp8_reg)
              + ((l2x_pkg::WPROD_W+1)'(1) << (l2x_pkg::OSHIFT - 1));
        o_mag = o_sum[l2x_pkg::OSHIFT +: l2x_pkg::ORND_W];
        if (neg8_reg)
        begin
            if (o_mag > l2x_pkg::ORND_W'(l2x_pkg::OUT_LOW_M))
            begin
                tristim_next = l2x_pkg::OUT_LOW;
            end
            else
            begin
                tristim_next = l2x_pkg::OUT_W'(0) - o_mag[l2x_pkg::OUT_W-1:0];
            end
        end
        else
        begin
            if (o_mag > l2x_pkg::ORND_W'(l2x_pkg::OUT_HIGH))
            begin
                tristim_next = l2x_pkg::OUT_W'(l2x_pkg::OUT_HIGH);
            end
            else
            begin
                tristim_next = o_mag[l2x_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            m2_reg   <= m2_next;
            neg2_reg <= neg2_next;
            n2_reg   <= n2_next;
        end
        if (ld[3])
        begin
            sqp3_reg  <= sqp3_next;
            m3_reg    <= m2_reg;
            neg3_reg  <= neg2_reg;
            v3_reg    <= v3_next;
            lneg3_reg <= lneg3_next;
        end
        if (ld[4])
        begin
            sq4_reg   <= sq4_next;
            m4_reg    <= m3_reg;
            neg4_reg  <= neg3_reg;
            lph4_reg  <= lph4_next;
            lpl4_reg  <= lpl4_next;
            lneg4_reg <= lneg3_reg;
        end
        if (ld[5])
        begin
            cup5_reg  <= cup5_next;
            neg5_reg  <= neg4_reg;
            lq5_reg   <= lq5_next;
            lneg5_reg <= lneg4_reg;
        end
        if (ld[6])
        begin
            cube6_reg <= cube6_next;
            lin6_reg  <= lin6_next;
        end
        if (ld[7])
        begin
            rmag7_reg <= rmag7_next;
            neg7_reg  <= neg7_next;
        end
        if (ld[8])
        begin
            wp8_reg  <= wp8_next;
            neg8_reg <= neg7_reg;
        end
        if (ld[9])
        begin
            tristim_reg <= tristim_next;
        end
    end

    assign tristim = tristim_reg;

endmodule

// ----- design/lab_to_xyz_converter.sv -----
// ----------------------------------------------------------------------------
// lab_to_xyz_converter: CIE L*a*b* to XYZ colour conversion
// Streams one L*a*b* pixel in and one XYZ pixel out per transfer, scaled by
// a programmable reference white (D65 after reset).
// ----------------------------------------------------------------------------
// Usage:
// Input pixels arrive on s_tvalid/s_tready/s_tdata; each result leaves on
// m_tvalid/m_tready/m_tdata in input order. All values are fixed point with
// 8 fraction bits. The pipeline has ten register stages, and a new pixel can
// be taken on every cycle for a sustained rate of one pixel per clock while
// the receiver keeps m_tready high.
// Each stage passes its item on as soon as the next stage is free, so when
// the receiver holds m_tready low the empty stages still fill and s_tready
// only drops once all ten stages hold a pixel. Nothing is dropped or sent
// twice across a stall.
// The reference white is written through cfg_valid/cfg_ready/cfg_index/
// cfg_data (index 0 = X, 1 = Y, 2 = Z, others ignored); cfg_ready is always
// high. Write it only while no pixel is in flight.
// Reset (rst_n low) empties the pipeline and restores the D65 white.
// ----------------------------------------------------------------------------
module lab_to_xyz_converter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // lightness[14:0], green_red[30:15], blue_yellow[46:31], zero[47]
    input  logic [l2x_pkg::S_DATA_W-1:0]      s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tristim_x[17:0], tristim_y[35:18], tristim_z[53:36], zero[55:54]
    output logic [l2x_pkg::M_DATA_W-1:0]      m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [l2x_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [l2x_pkg::WHITE_W-1:0]       cfg_data
);

    // Pipeline control.
    logic [l2x_pkg::NSTAGE-1:0] valid_reg, valid_next;
    logic [l2x_pkg::NSTAGE-1:0] ld;

    // Reference white.
    logic [l2x_pkg::WHITE_W-1:0] white_x_reg, white_x_next;
    logic [l2x_pkg::WHITE_W-1:0] white_y_reg, white_y_next;
    logic [l2x_pkg::WHITE_W-1:0] white_z_reg, white_z_next;

    // Input fields.
    logic [l2x_pkg::L_W-1:0]   lightness;
    logic [l2x_pkg::AB_W-1:0]  green_red;
    logic [l2x_pkg::AB_W-1:0]  blue_yellow;

    // Stage 0: front divisions.
    logic [l2x_pkg::LS_W-1:0]    l_sum;
    logic [l2x_pkg::AB_W-1:0]    a_mag;
    logic [l2x_pkg::AB_W-1:0]    b_mag;
    logic [l2x_pkg::NUMY_W-1:0]  num_y;
    logic [l2x_pkg::NUMX_W-1:0]  num_x;
    logic [l2x_pkg::NUMZ_W-1:0]  num_z;
    logic [l2x_pkg::PRODY_W-1:0] prod_y;
    logic [l2x_pkg::PRODX_W-1:0] prod_x;
    logic [l2x_pkg::PRODZ_W-1:0] prod_z;
    logic [l2x_pkg::QY_W-1:0]    qy_reg, qy_next;
    logic [l2x_pkg::QX_W-1:0]    qx_reg, qx_next;
    logic [l2x_pkg::QZ_W-1:0]    qz_reg, qz_next;
    logic                        neg_a_reg, neg_a_next;
    logic                        neg_b_reg, neg_b_next;

    // Stage 1: fx, fy, fz.
    logic signed [l2x_pkg::F_W-1:0] fy_base;
    logic signed [l2x_pkg::F_W-1:0] dx;
    logic signed [l2x_pkg::F_W-1:0] dz;
    logic signed [l2x_pkg::F_W-1:0] fx_reg, fx_next;
    logic signed [l2x_pkg::F_W-1:0] fy_reg, fy_next;
    logic signed [l2x_pkg::F_W-1:0] fz_reg, fz_next;

    // Outputs of the channel datapaths.
    logic [l2x_pkg::OUT_W-1:0] tristim_x;
    logic [l2x_pkg::OUT_W-1:0] tristim_y;
    logic [l2x_pkg::OUT_W-1:0] tristim_z;

    // A stage loads when it is empty or when its item moves on this cycle.
    always_comb
    begin
        ld[l2x_pkg::NSTAGE-1] = !valid_reg[l2x_pkg::NSTAGE-1] || m_tready;
        for (int i = l2x_pkg::NSTAGE - 2; i >= 0; i--)
        begin
            ld[i] = !valid_reg[i] || ld[i+1];
        end
        valid_next[0] = ld[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < l2x_pkg::NSTAGE; i++)
        begin
            valid_next[i] = ld[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    assign s_tready  = ld[0];
    assign m_tvalid  = valid_reg[l2x_pkg::NSTAGE-1];
    assign cfg_ready = 1'b1;

    always_comb
    begin
        white_x_next = white_x_reg;
        white_y_next = white_y_reg;
        white_z_next = white_z_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                l2x_pkg::REG_WHITE_X: white_x_next = cfg_data;
                l2x_pkg::REG_WHITE_Y: white_y_next = cfg_data;
                l2x_pkg::REG_WHITE_Z: white_z_next = cfg_data;
                default:              white_x_next = white_x_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            white_x_reg <= l2x_pkg::WHITE_X_RST;
            white_y_reg <= l2x_pkg::WHITE_Y_RST;
            white_z_reg <= l2x_pkg::WHITE_Z_RST;
        end
        else
        begin
            valid_reg   <= valid_next;
            white_x_reg <= white_x_next;
            white_y_reg <= white_y_next;
            white_z_reg <= white_z_next;
        end
    end

    assign lightness   = s_tdata[l2x_pkg::L_W-1:0];
    assign green_red   = s_tdata[l2x_pkg::L_W +: l2x_pkg::AB_W];
    assign blue_yellow = s_tdata[l2x_pkg::L_W + l2x_pkg::AB_W +: l2x_pkg::AB_W];

    // (L+16)/116, |a|/500 and |b|/200 in guard format, each rounded half away
    // from zero on the magnitude.
    always_comb
    begin
        l_sum      = l2x_pkg::LS_W'(lightness) + l2x_pkg::L_OFFSET;
        a_mag      = green_red[l2x_pkg::AB_W-1] ? (~green_red + 1'b1) : green_red;
        b_mag      = blue_yellow[l2x_pkg::AB_W-1] ? (~blue_yellow + 1'b1) : blue_yellow;
        num_y      = {l_sum, {l2x_pkg::FY_SHIFT{1'b0}}} + l2x_pkg::NUMY_W'(l2x_pkg::FY_BIAS);
        num_x      = {a_mag, {l2x_pkg::FX_SHIFT{1'b0}}} + l2x_pkg::NUMX_W'(l2x_pkg::FX_BIAS);
        num_z      = {b_mag, {l2x_pkg::FZ_SHIFT{1'b0}}} + l2x_pkg::NUMZ_W'(l2x_pkg::FZ_BIAS);
        prod_y     = l2x_pkg::PRODY_W'(num_y) * l2x_pkg::PRODY_W'(l2x_pkg::RECIP_Y);
        prod_x     = l2x_pkg::PRODX_W'(num_x) * l2x_pkg::PRODX_W'(l2x_pkg::RECIP_X);
        prod_z     = l2x_pkg::PRODZ_W'(num_z) * l2x_pkg::PRODZ_W'(l2x_pkg::RECIP_Z);
        qy_next    = prod_y[l2x_pkg::FY_K +: l2x_pkg::QY_W];
        qx_next    = prod_x[l2x_pkg::FX_K +: l2x_pkg::QX_W];
        qz_next    = prod_z[l2x_pkg::FZ_K +: l2x_pkg::QZ_W];
        neg_a_next = green_red[l2x_pkg::AB_W-1];
        neg_b_next = blue_yellow[l2x_pkg::AB_W-1];
    end

    always_comb
    begin
        fy_base = $signed(l2x_pkg::F_W'(qy_reg));
        dx      = $signed(l2x_pkg::F_W'(qx_reg));
        dz      = $signed(l2x_pkg::F_W'(qz_reg));
        fy_next = fy_base;
        fx_next = neg_a_reg ? (fy_base - dx) : (fy_base + dx);
        fz_next = neg_b_reg ? (fy_base + dz) : (fy_base - dz);
    end

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            qy_reg    <= qy_next;
            qx_reg    <= qx_next;
            qz_reg    <= qz_next;
            neg_a_reg <= neg_a_next;
            neg_b_reg <= neg_b_next;
        end
        if (ld[1])
        begin
            fx_reg <= fx_next;
            fy_reg <= fy_next;
            fz_reg <= fz_next;
        end
    end

    l2x_channel u_chan_x (
        .clk     (clk),
        .ld      (ld),
        .f       (fx_reg),
        .white   (white_x_reg),
        .tristim (tristim_x)
    );

    l2x_channel u_chan_y (
        .clk     (clk),
        .ld      (ld),
        .f       (fy_reg),
        .white   (white_y_reg),
        .tristim (tristim_y)
    );

    l2x_channel u_chan_z (
        .clk     (clk),
        .ld      (ld),
        .f       (fz_reg),
        .white   (white_z_reg),
        .tristim (tristim_z)
    );

    assign m_tdata = {(l2x_pkg::M_DATA_W - 3 * l2x_pkg::OUT_W)'(0),
                      tristim_z, tristim_y, tristim_x};

    // The input side only stalls when every stage holds an item.
    a_stall_only_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg))
        else $error("input stalled while a pipeline stage was empty");

    // An item moving into the output register shows up as a result.
    a_item_reaches_output: assert property (
        @(posedge clk) disable iff (!rst_n)
        (valid_reg[l2x_pkg::NSTAGE-2] && ld[l2x_pkg::NSTAGE-1]) |=> m_tvalid)
        else $error("item lost between the last two stages");

    // Saturation keeps every result at or above the lower limit.
    a_output_floor: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (($signed(tristim_x) >= l2x_pkg::OUT_LOW)
                   && ($signed(tristim_y) >= l2x_pkg::OUT_LOW)
                   && ($signed(tristim_z) >= l2x_pkg::OUT_LOW)))
        else $error("result below the saturation floor");

    // A white Y transfer lands in its register on the next cycle.
    a_white_y_write: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && (cfg_index == l2x_pkg::REG_WHITE_Y))
        |=> (white_y_reg == $past(cfg_data)))
        else $error("white Y register did not take the written value");

endmodule

// ----- sim/lab_to_xyz_converter_tb.sv -----
// ----------------------------------------------------------------------------
// lab_to_xyz_converter_tb: self-checking bench for the L*a*b* to XYZ converter
// Streams directed and random pixels through the converter under several
// reference-white settings and compares every XYZ result, field by field,
// with an in-bench fixed-point model. Both stream sides idle at random, and
// the output side holds off once long enough to back the pipeline up.
// ----------------------------------------------------------------------------
module lab_to_xyz_converter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int G_FRAC           = l2x_pkg::FRAC_BITS + 16;
    localparam int SAT_HIGH         = 131071;
    localparam int SAT_LOW          = -4096;
    localparam int MAX_WAIT         = 18;
    localparam int HOLD_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 2000;
    localparam int PIXELS_PER_PHASE = 210;
    localparam int NUM_CASES        = 16;

    // Index 3 is not a register; writes to it must leave the white point alone.
    localparam logic [l2x_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [15:0] blue_yellow;
        logic signed [15:0] green_red;
        logic        [14:0] lightness;
    } lab_t;

    typedef struct packed {
        logic signed [17:0] tristim_z;
        logic signed [17:0] tristim_y;
        logic signed [17:0] tristim_x;
    } xyz_t;

    typedef struct packed {
        bit          typed;
        logic [14:0] l;
        logic [15:0] a;
        logic [15:0] b;
        logic [17:0] x;
        logic [17:0] y;
        logic [17:0] z;
    } lab_case_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [l2x_pkg::S_DATA_W-1:0]         s_tdata;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [l2x_pkg::M_DATA_W-1:0]         m_tdata;
    logic                                 cfg_valid;
    logic                                 cfg_ready;
    logic [l2x_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [l2x_pkg::WHITE_W-1:0]          cfg_data;

    // White point as the converter should currently hold it.
    logic [15:0] wp_x;
    logic [15:0] wp_y;
    logic [15:0] wp_z;

    xyz_t xyz_pending[$];

    int  errors;
    int  pixels_sent;
    int  results_seen;
    int  sat_high_seen;
    int  sat_low_seen;
    int  white_settings;
    int  quiet_cycles;
    int  source_calm;
    int  sink_calm;
    bit  hold_req;
    bit  hold_done;

    // Rows marked typed carry the result straight from the formulas: black
    // gives zero, and L* = 100 with a* = b* = 0 gives exactly the D65 white.
    lab_case_t lab_cases [NUM_CASES] = '{
        '{1'b1, 15'd0,     16'h0000, 16'h0000, 18'd0,     18'd0,     18'd0},
        '{1'b1, 15'd25600, 16'h0000, 16'h0000, 18'd24332, 18'd25600, 18'd27874},
        '{1'b0, 15'd32767, 16'h7fff, 16'h8000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd32767, 16'h8000, 16'h7fff, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd0,     16'h8000, 16'h7fff, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd0,     16'h7fff, 16'h8000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd2047,  16'h0000, 16'h0000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd2048,  16'h0000, 16'h0000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd2049,  16'h0000, 16'h0000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd1,     16'h0001, 16'hffff, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd0,     16'hffff, 16'h0001, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd25600, 16'h7fff, 16'h7fff, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd25600, 16'h8000, 16'h8000, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd21845, 16'h5555, 16'haaaa, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd10922, 16'haaaa, 16'h5555, 18'd0,     18'd0,     18'd0},
        '{1'b0, 15'd2048,  16'h00ff, 16'hff00, 18'd0,     18'd0,     18'd0}
    };

    lab_to_xyz_converter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Round half away from zero on the magnitude, sign restored afterwards.
    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic longint round_shr(input longint v, input int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // Inverse companding of one channel: f^3 above the knee, linear below it.
    function automatic longint lab_ratio(input longint f);
        longint mag;
        longint sq;
        longint cube;
        longint knee;
        mag  = (f < 0) ? -f : f;
        sq   = round_shr(mag * mag, G_FRAC);
        cube = round_shr(sq * mag, G_FRAC);
        if (f < 0)
            cube = -cube;
        knee = round_div(64'sd8856 <<< G_FRAC, 1000000);
        if (cube > knee)
            return cube;
        return round_div((116 * f - (64'sd16 <<< G_FRAC)) * 10, 9033);
    endfunction

    function automatic logic signed [17:0] scale_white(input longint ratio,
                                                       input logic [15:0] white);
        longint v;
        v = round_div(ratio * longint'(white), 64'sd1 <<< 24);
        if (v < SAT_LOW)
            v = SAT_LOW;
        else if (v > SAT_HIGH)
            v = SAT_HIGH;
        return v[17:0];
    endfunction

    function automatic xyz_t lab_to_xyz(input lab_t px);
        longint fy;
        longint fx;
        longint fz;
        xyz_t   xyz;
        fy = round_div((longint'(px.lightness) + (64'sd16 <<< l2x_pkg::FRAC_BITS))
                       * 65536, 116);
        fx = fy + round_div(longint'(px.green_red) * 65536, 500);
        fz = fy - round_div(longint'(px.blue_yellow) * 65536, 200);
        xyz.tristim_x = scale_white(lab_ratio(fx), wp_x);
        xyz.tristim_y = scale_white(lab_ratio(fy), wp_y);
        xyz.tristim_z = scale_white(lab_ratio(fz), wp_z);
        return xyz;
    endfunction

    // Per-transfer wait, with occasional runs of back-to-back transfers.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    // Called at a rising edge; returns at the rising edge of the transfer with
    // s_tvalid still high.
    task automatic send_pixel(input lab_t px, input bit typed, input xyz_t typed_xyz);
        int gap;
        gap = draw_wait(source_calm);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, px};
        do
            @(negedge clk);
        while (!s_tready);
        xyz_pending.push_back(typed ? typed_xyz : lab_to_xyz(px));
        pixels_sent++;
        @(posedge clk);
    endtask

    task automatic run_pixels(input int count, input int hold_at);
        lab_t px;
        xyz_t none;
        none = '0;
        for (int i = 0; i < count; i++)
        begin
            if (i == hold_at)
                hold_req = 1'b1;
            px.green_red   = 16'($urandom);
            px.blue_yellow = 16'($urandom);
            case ($urandom_range(0, 9))
                0:       px.lightness = 15'($urandom);
                1:
                begin
                    px.lightness   = 15'($urandom_range(0, 25600));
                    px.green_red   = 16'(int'($urandom_range(0, 1023)) - 512);
                    px.blue_yellow = 16'(int'($urandom_range(0, 1023)) - 512);
                end
                default: px.lightness = 15'($urandom_range(0, 25600));
            endcase
            send_pixel(px, 1'b0, none);
        end
        s_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (xyz_pending.size() != 0)
            @(posedge clk);
    endtask

    // Writes the three white registers back to back; optionally slips a write
    // to the unused index in between, which must change nothing.
    task automatic write_white(input logic [15:0] wx, input logic [15:0] wy,
                               input logic [15:0] wz, input bit with_unused);
        logic [l2x_pkg::CFG_IDX_W-1:0] idx [$];
        logic [15:0]                   val [$];
        idx = '{l2x_pkg::REG_WHITE_X, l2x_pkg::REG_WHITE_Y, l2x_pkg::REG_WHITE_Z};
        val = '{wx, wy, wz};
        if (with_unused)
        begin
            idx.insert(1, REG_UNUSED);
            val.insert(1, 16'($urandom));
        end
        for (int i = 0; i < idx.size(); i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            do
                @(negedge clk);
            while (!cfg_ready);
            case (idx[i])
                l2x_pkg::REG_WHITE_X: wp_x = val[i];
                l2x_pkg::REG_WHITE_Y: wp_y = val[i];
                l2x_pkg::REG_WHITE_Z: wp_z = val[i];
                default: ;
            endcase
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        white_settings++;
    endtask

    always @(negedge clk)
    begin : xyz_monitor
        xyz_t got;
        xyz_t want;
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[53:0];
                results_seen++;
                if (got.tristim_x == SAT_HIGH || got.tristim_y == SAT_HIGH ||
                    got.tristim_z == SAT_HIGH)
                    sat_high_seen++;
                if (got.tristim_x == SAT_LOW || got.tristim_y == SAT_LOW ||
                    got.tristim_z == SAT_LOW)
                    sat_low_seen++;
                if (xyz_pending.size() == 0)
                begin
                    errors++;
                    $error("XYZ transfer with no pixel outstanding: %h", m_tdata);
                end
                else
                begin
                    want = xyz_pending.pop_front();
                    if (got.tristim_x !== want.tristim_x)
                    begin
                        errors++;
                        $error("tristim_x: expected %0d, got %0d",
                               want.tristim_x, got.tristim_x);
                    end
                    if (got.tristim_y !== want.tristim_y)
                    begin
                        errors++;
                        $error("tristim_y: expected %0d, got %0d",
                               want.tristim_y, got.tristim_y);
                    end
                    if (got.tristim_z !== want.tristim_z)
                    begin
                        errors++;
                        $error("tristim_z: expected %0d, got %0d",
                               want.tristim_z, got.tristim_z);
                    end
                    if (m_tdata[l2x_pkg::M_DATA_W-1:54] !== '0)
                    begin
                        errors++;
                        $error("m_tdata pad bits: expected 0, got %b",
                               m_tdata[l2x_pkg::M_DATA_W-1:54]);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        do
            @(negedge clk);
        while (quiet_cycles < QUIET_LIMIT);
        $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Output side: random stalls per transfer, plus one long hold-off on request
    // so the pipeline fills and the input side backs up.
    initial
    begin : xyz_sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            stall = draw_wait(sink_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(negedge clk);
            while (!m_tvalid);
            @(posedge clk);
        end
    end

    initial
    begin : stimulus
        lab_t px;
        xyz_t typed_xyz;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = l2x_pkg::REG_WHITE_X;
        cfg_data  = '0;
        wp_x      = 16'd24332;
        wp_y      = 16'd25600;
        wp_z      = 16'd27874;
        white_settings = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // D65 white straight out of reset: directed corners, then random pixels.
        foreach (lab_cases[i])
        begin
            px.lightness   = lab_cases[i].l;
            px.green_red   = lab_cases[i].a;
            px.blue_yellow = lab_cases[i].b;
            typed_xyz.tristim_x = lab_cases[i].x;
            typed_xyz.tristim_y = lab_cases[i].y;
            typed_xyz.tristim_z = lab_cases[i].z;
            send_pixel(px, lab_cases[i].typed, typed_xyz);
        end
        run_pixels(PIXELS_PER_PHASE, -1);
        wait_drained();

        // Largest white: drives many results into high saturation. The long
        // output hold-off falls in this phase.
        write_white(16'hffff, 16'hffff, 16'hffff, 1'b1);
        run_pixels(PIXELS_PER_PHASE, 40);
        wait_drained();

        write_white(16'h0000, 16'h0000, 16'h0000, 1'b0);
        run_pixels(PIXELS_PER_PHASE / 2, -1);
        wait_drained();

        for (int k = 0; k < 2; k++)
        begin
            write_white(16'($urandom), 16'($urandom), 16'($urandom), 1'b1);
            run_pixels(PIXELS_PER_PHASE, -1);
            wait_drained();
        end

        write_white(16'd24332, 16'd25600, 16'd27874, 1'b0);
        run_pixels(PIXELS_PER_PHASE + PIXELS_PER_PHASE / 2, -1);
        wait_drained();

        // Let any stray result surface before the verdict.
        repeat (l2x_pkg::NSTAGE + 2 * MAX_WAIT) @(posedge clk);

        $display("Sent %0d pixels (%0d directed) under %0d white-point settings.",
                 pixels_sent, NUM_CASES, white_settings);
        $display("Checked %0d XYZ results; %0d hit the upper clamp, %0d the lower.",
                 results_seen, sat_high_seen, sat_low_seen);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
design/l2x_pkg.sv
design/l2x_channel.sv
design/lab_to_xyz_converter.sv
sim/lab_to_xyz_converter_tb.sv
